/* rtl/core/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked property checks; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

/* rtl/core/deq_pkg.sv */
// ---------------------------------------------------------------------------
// deq_pkg
// Shared widths, request codes and control/status types of the deque.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package deq_pkg;

  localparam int MODE_W      = 3;
  localparam int ID_W        = 16;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 5;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 56;

  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND       = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd5;

  typedef struct packed {
    logic capture;
    logic push_back;
    logic push_front;
    logic pop_front;
    logic pop_back;
    logic clear;
    logic scan_clr;
    logic scan_issue;
    logic pop_take;
    logic found_set;
    logic out_load;
  } deq_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              scan_more;
    logic              cmp_v;
    logic              hit;
  } deq_sts_t;

endpackage

/* rtl/core/double_ended_queue.sv */
// ---------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of process records in a ring buffer: push/pop at either
// end, id search and clear, one result item per request item.
// ---------------------------------------------------------------------------
// Channel | Dir | Handshake           | Payload
// in_     | in  | in_tvalid/in_tready  | in_tdata: mode, item_id, item_data
// out_    | out | out_tvalid/out_tready| out_tdata: ok, found, out_id,
//         |     |                      |   out_data, count
//
// One item at a time. Push, clear and failed ops go from execute to response;
// pops add a read step; find adds a scan, one entry compared per cycle
// through the single read port of the entry memory.
// Reset clears state, head, count, scan index and valid flags; the entry memory needs no clearing.
// A stalled result sits in the output register; the next item is taken
// once it has been loaded there.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // mode[2:0], item_id[18:3], item_data[50:19], zero fill
  input  logic [deq_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // ok[0], found[1], out_id[17:2], out_data[49:18], count[54:50], zero fill
  output logic [deq_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  deq_pkg::deq_cmd_t cmd;
  deq_pkg::deq_sts_t sts;

  logic                         res_ok;
  logic                         res_found;
  logic [deq_pkg::ID_W-1:0]     res_id;
  logic [deq_pkg::DATA_W-1:0]   res_data;
  logic [deq_pkg::COUNT_W-1:0]  res_count;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  deq_dp #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .in_mode_i   (in_tdata[2:0]),
    .in_id_i     (in_tdata[18:3]),
    .in_data_i   (in_tdata[50:19]),
    .sts_o       (sts),
    .out_ok_o    (res_ok),
    .out_found_o (res_found),
    .out_id_o    (res_id),
    .out_data_o  (res_data),
    .out_count_o (res_count)
  );

  assign out_tdata = {1'b0, res_count, res_data, res_id, res_found, res_ok};

endmodule

/* rtl/core/deq_ctrl.sv */
// ---------------------------------------------------------------------------
// deq_ctrl
// Request sequencer: steps each item through execute, read, scan and
// response, and owns the output valid flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  deq_pkg::deq_sts_t sts_i,
  output deq_pkg::deq_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_tvalid_r;
  logic       out_tvalid_nxt;
  logic       out_free;

  assign out_free   = !out_tvalid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd_o     = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        unique case (sts_i.mode)
          deq_pkg::MODE_PUSH_BACK:  cmd_o.push_back  = !sts_i.full;
          deq_pkg::MODE_PUSH_FRONT: cmd_o.push_front = !sts_i.full;
          deq_pkg::MODE_POP_FRONT: begin
            if (!sts_i.empty) begin
              cmd_o.pop_front = 1'b1;
              state_nxt       = S_READ;
            end
          end
          deq_pkg::MODE_POP_BACK: begin
            if (!sts_i.empty) begin
              cmd_o.pop_back = 1'b1;
              state_nxt      = S_READ;
            end
          end
          deq_pkg::MODE_FIND: begin
            cmd_o.scan_clr = 1'b1;
            state_nxt      = S_SCAN;
          end
          deq_pkg::MODE_CLEAR: cmd_o.clear = 1'b1;
          default: ;
        endcase
      end
      S_READ: begin
        cmd_o.pop_take = 1'b1;
        state_nxt      = S_RESP;
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.found_set = 1'b1;
          state_nxt       = S_RESP;
        end else if (sts_i.scan_more) begin
          cmd_o.scan_issue = 1'b1;
        end else if (!sts_i.cmp_v) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (cmd_o.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule

/* rtl/core/deq_dp.sv */
// ---------------------------------------------------------------------------
// deq_dp
// Datapath: entry memory ring, head and count registers, scan index,
// result and output registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module deq_dp #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  deq_pkg::deq_cmd_t             cmd_i,
  input  logic [deq_pkg::MODE_W-1:0]    in_mode_i,
  input  logic [deq_pkg::ID_W-1:0]      in_id_i,
  input  logic [deq_pkg::DATA_W-1:0]    in_data_i,
  output deq_pkg::deq_sts_t             sts_o,
  output logic                          out_ok_o,
  output logic                          out_found_o,
  output logic [deq_pkg::ID_W-1:0]      out_id_o,
  output logic [deq_pkg::DATA_W-1:0]    out_data_o,
  output logic [deq_pkg::COUNT_W-1:0]   out_count_o
);

  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int PW     = (PAYLOAD_BITS < deq_pkg::DATA_W) ? PAYLOAD_BITS : deq_pkg::DATA_W;
  localparam int DW     = deq_pkg::DATA_W;
  localparam int CNT_OW = deq_pkg::COUNT_W;

  localparam logic [AW:0]   DEPTH_S   = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [deq_pkg::ID_W-1:0] mem_id [DEPTH];
  logic [PW-1:0]            mem_pl [DEPTH];

  logic [AW-1:0]              head_r;
  logic [AW-1:0]              head_nxt;
  logic [CW-1:0]              cnt_r;
  logic [CW-1:0]              cnt_nxt;
  logic [CW-1:0]              scan_idx_r;
  logic [CW-1:0]              scan_idx_nxt;
  logic                       cmp_v_r;
  logic [deq_pkg::MODE_W-1:0] mode_r;
  logic [deq_pkg::ID_W-1:0]   id_r;
  logic [PW-1:0]              data_r;
  logic [deq_pkg::ID_W-1:0]   rd_id_r;
  logic [PW-1:0]              rd_pl_r;
  logic                       res_ok_r;
  logic                       res_found_r;
  logic [deq_pkg::ID_W-1:0]   res_id_r;
  logic [PW-1:0]              res_data_r;
  logic                       out_ok_r;
  logic                       out_found_r;
  logic [deq_pkg::ID_W-1:0]   out_id_r;
  logic [DW-1:0]              out_data_r;
  logic [CNT_OW-1:0]          out_count_r;

  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] off;
  logic [AW:0]   sum;
  logic [AW:0]   slot_w;
  logic [AW-1:0] slot;
  logic [AW-1:0] raddr;
  logic          we;
  logic          re;
  logic          full;

  assign cnt_m1 = cnt_r - CW'(1);
  assign full   = (cnt_r == DEPTH_C);

  always_comb begin
    off = '0;
    if (cmd_i.push_back) begin
      off = cnt_r[AW-1:0];
    end else if (cmd_i.push_front) begin
      off = LAST_SLOT;
    end else if (cmd_i.pop_back) begin
      off = cnt_m1[AW-1:0];
    end else if (cmd_i.scan_issue) begin
      off = scan_idx_r[AW-1:0];
    end
  end

  assign sum    = {1'b0, head_r} + {1'b0, off};
  assign slot_w = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;
  assign slot   = slot_w[AW-1:0];
  assign raddr  = cmd_i.pop_front ? head_r : slot;
  assign we     = cmd_i.push_back || cmd_i.push_front;
  assign re     = cmd_i.pop_front || cmd_i.pop_back || cmd_i.scan_issue;

  always_comb begin
    head_nxt     = head_r;
    cnt_nxt      = cnt_r;
    scan_idx_nxt = scan_idx_r;
    if (cmd_i.clear) begin
      head_nxt = '0;
      cnt_nxt  = '0;
    end
    if (we) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (cmd_i.push_front) begin
      head_nxt = slot;
    end
    if (cmd_i.pop_front || cmd_i.pop_back) begin
      cnt_nxt = cnt_m1;
    end
    if (cmd_i.pop_front) begin
      head_nxt = (head_r == LAST_SLOT) ? '0 : head_r + AW'(1);
    end
    if (cmd_i.scan_clr) begin
      scan_idx_nxt = '0;
    end else if (cmd_i.scan_issue) begin
      scan_idx_nxt = scan_idx_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      cnt_r      <= '0;
      scan_idx_r <= '0;
      cmp_v_r    <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      cnt_r      <= cnt_nxt;
      scan_idx_r <= scan_idx_nxt;
      cmp_v_r    <= cmd_i.scan_issue;
    end
  end

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_id[slot] <= id_r;
      mem_pl[slot] <= data_r;
    end
    if (re) begin
      rd_id_r <= mem_id[raddr];
      rd_pl_r <= mem_pl[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      mode_r      <= in_mode_i;
      id_r        <= in_id_i;
      data_r      <= in_data_i[PW-1:0];
      res_ok_r    <= 1'b0;
      res_found_r <= 1'b0;
      res_id_r    <= '0;
      res_data_r  <= '0;
    end else begin
      if (we || cmd_i.clear || cmd_i.pop_front || cmd_i.pop_back) begin
        res_ok_r <= 1'b1;
      end
      if (cmd_i.pop_take) begin
        res_id_r   <= rd_id_r;
        res_data_r <= rd_pl_r;
      end
      if (cmd_i.found_set) begin
        res_found_r <= 1'b1;
      end
    end
    if (cmd_i.out_load) begin
      out_ok_r    <= res_ok_r;
      out_found_r <= res_found_r;
      out_id_r    <= res_id_r;
      out_data_r  <= DW'(res_data_r);
      out_count_r <= CNT_OW'(cnt_r);
    end
  end

  assign sts_o.mode      = mode_r;
  assign sts_o.full      = full;
  assign sts_o.empty     = (cnt_r == '0);
  assign sts_o.scan_more = (scan_idx_r < cnt_r);
  assign sts_o.cmp_v     = cmp_v_r;
  assign sts_o.hit       = cmp_v_r && (rd_id_r == id_r);

  assign out_ok_o    = out_ok_r;
  assign out_found_o = out_found_r;
  assign out_id_o    = out_id_r;
  assign out_data_o  = out_data_r;
  assign out_count_o = out_count_r;

  `ASSERT_AT(a_cnt_le_depth, clk, rst_n, cnt_r <= DEPTH_C, "entry count above depth")
  `ASSERT_AT(a_head_in_ring, clk, rst_n, {1'b0, head_r} < DEPTH_S, "head outside ring")
  `ASSERT_NEVER(a_push_full, clk, rst_n, we && full, "push into full queue")
  `ASSERT_NEVER(a_wr_rd_same, clk, rst_n, we && re, "write and read in one cycle")
  `ASSERT_AT(a_pop_dec, clk, rst_n, (cmd_i.pop_front || cmd_i.pop_back) |=> (cnt_r == $past(cnt_m1)), "pop did not decrement count")

endmodule

/* tb/sv/double_ended_queue_tb.sv */
// ---------------------------------------------------------------------------
// double_ended_queue_tb
// Drives push, pop, find and clear requests into the deque over the input
// stream and checks every result item against a ring-buffer mirror of the
// queue kept in the bench. Covers empty and full corners, unused modes, a
// long output stall that backs up the input, and random traffic with idle
// bursts on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue_tb;

  localparam int QDEPTH   = 16;
  localparam int SLOT_W   = $clog2(QDEPTH);
  localparam int MW       = deq_pkg::MODE_W;
  localparam int IW       = deq_pkg::ID_W;
  localparam int DW       = deq_pkg::DATA_W;
  localparam int CNTW     = deq_pkg::COUNT_W;
  localparam int IN_TW    = deq_pkg::IN_TDATA_W;
  localparam int OUT_TW   = deq_pkg::OUT_TDATA_W;
  localparam int IN_PAD_W = IN_TW - MW - IW - DW;
  localparam int LIMIT    = 600000;

  localparam logic [MW-1:0] MODE_UNUSED_A = 3'd6;
  localparam logic [MW-1:0] MODE_UNUSED_B = 3'd7;

  typedef struct packed {
    logic            ok;
    logic            found;
    logic [IW-1:0]   id;
    logic [DW-1:0]   data;
    logic [CNTW-1:0] count;
  } deq_reply_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_TW-1:0]  in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_TW-1:0] out_tdata;

  logic [IW-1:0]     mirror_ids [QDEPTH];
  logic [DW-1:0]     mirror_data [QDEPTH];
  logic [SLOT_W-1:0] mirror_head = '0;
  logic [CNTW-1:0]   mirror_count = '0;

  deq_reply_t deque_replies[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         hold_len = 0;
  bit         sender_idle = 1'b1;
  bit         receiver_idle = 1'b1;

  double_ended_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic deq_reply_t apply_deque_op(input logic [MW-1:0] mode,
                                                input logic [IW-1:0] id,
                                                input logic [DW-1:0] data);
    deq_reply_t        r;
    logic [SLOT_W-1:0] slot;
    int                i;
    r = '0;
    case (mode)
      deq_pkg::MODE_PUSH_BACK: begin
        if (mirror_count < QDEPTH) begin
          slot = mirror_head + mirror_count[SLOT_W-1:0];
          mirror_ids[slot]  = id;
          mirror_data[slot] = data;
          mirror_count++;
          r.ok = 1'b1;
        end
      end
      deq_pkg::MODE_PUSH_FRONT: begin
        if (mirror_count < QDEPTH) begin
          slot = mirror_head - 1'b1;
          mirror_ids[slot]  = id;
          mirror_data[slot] = data;
          mirror_head = slot;
          mirror_count++;
          r.ok = 1'b1;
        end
      end
      deq_pkg::MODE_POP_FRONT: begin
        if (mirror_count > 0) begin
          r.id   = mirror_ids[mirror_head];
          r.data = mirror_data[mirror_head];
          mirror_head = mirror_head + 1'b1;
          mirror_count--;
          r.ok = 1'b1;
        end
      end
      deq_pkg::MODE_POP_BACK: begin
        if (mirror_count > 0) begin
          slot = mirror_head + mirror_count[SLOT_W-1:0] - 1'b1;
          r.id   = mirror_ids[slot];
          r.data = mirror_data[slot];
          mirror_count--;
          r.ok = 1'b1;
        end
      end
      deq_pkg::MODE_FIND: begin
        for (i = 0; i < mirror_count; i++) begin
          slot = mirror_head + SLOT_W'(i);
          if (mirror_ids[slot] == id) r.found = 1'b1;
        end
      end
      deq_pkg::MODE_CLEAR: begin
        mirror_head  = '0;
        mirror_count = '0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count = mirror_count;
    return r;
  endfunction

  // leaves in_tvalid high on return; the caller lowers it
  task automatic send_request(input logic [MW-1:0] mode, input logic [IW-1:0] id,
                              input logic [DW-1:0] data);
    int gap;
    gap = (sender_idle && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{IN_PAD_W{1'b0}}, data, id, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    deque_replies.push_back(apply_deque_op(mode, id, data));
  endtask

  function automatic void check_field(input string name, input logic [DW-1:0] want,
                                      input logic [DW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    deq_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (deque_replies.size() == 0) begin
        $error("result item with nothing pending");
        mismatch_count++;
      end else begin
        want = deque_replies.pop_front();
        check_field("ok", DW'(want.ok), DW'(out_tdata[0]));
        check_field("found", DW'(want.found), DW'(out_tdata[1]));
        check_field("out_id", DW'(want.id), DW'(out_tdata[17:2]));
        check_field("out_data", want.data, out_tdata[49:18]);
        check_field("count", DW'(want.count), DW'(out_tdata[54:50]));
      end
    end
  end

  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("double_ended_queue_tb: errors");
      $finish;
    end
  end

  task automatic test_directed_edges;
    send_request(deq_pkg::MODE_POP_FRONT, 16'h0000, 32'h0000_0000);
    send_request(deq_pkg::MODE_POP_BACK, 16'h0000, 32'h0000_0000);
    send_request(deq_pkg::MODE_FIND, 16'h0000, 32'h0000_0000);
    send_request(deq_pkg::MODE_PUSH_BACK, 16'h0000, 32'h0000_0000);
    send_request(deq_pkg::MODE_PUSH_FRONT, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(deq_pkg::MODE_FIND, 16'hFFFF, 32'h0000_0000);
    send_request(deq_pkg::MODE_FIND, 16'h0000, 32'hFFFF_FFFF);
    send_request(deq_pkg::MODE_FIND, 16'h1234, 32'h0000_0000);
    send_request(MODE_UNUSED_A, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(MODE_UNUSED_B, 16'h5A5A, 32'hA5A5_A5A5);
    send_request(deq_pkg::MODE_POP_BACK, 16'h0000, 32'h0000_0000);
    send_request(deq_pkg::MODE_POP_FRONT, 16'h0000, 32'h0000_0000);
    send_request(deq_pkg::MODE_PUSH_BACK, 16'hAAAA, 32'h5555_5555);
    send_request(deq_pkg::MODE_CLEAR, 16'h0000, 32'h0000_0000);
    send_request(deq_pkg::MODE_POP_FRONT, 16'h0000, 32'h0000_0000);
  endtask

  task automatic test_full_queue;
    int k;
    send_request(deq_pkg::MODE_CLEAR, 16'h0000, 32'h0000_0000);
    for (k = 0; k < QDEPTH; k++) begin
      send_request((k % 2) ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_PUSH_BACK,
                   16'h0100 + IW'(k), 32'hA500_0000 | DW'(k));
    end
    send_request(deq_pkg::MODE_PUSH_BACK, 16'hBEEF, 32'h1234_5678);
    send_request(deq_pkg::MODE_PUSH_FRONT, 16'hBEEF, 32'h1234_5678);
    send_request(deq_pkg::MODE_FIND, 16'h010F, 32'h0000_0000);
    send_request(deq_pkg::MODE_FIND, 16'h0200, 32'h0000_0000);
    send_request(deq_pkg::MODE_POP_FRONT, 16'h0000, 32'h0000_0000);
    send_request(deq_pkg::MODE_POP_BACK, 16'h0000, 32'h0000_0000);
    send_request(deq_pkg::MODE_CLEAR, 16'h0000, 32'h0000_0000);
  endtask

  // output held off for a long stretch while the input keeps offering items
  task automatic test_backpressure;
    int k;
    sender_idle = 1'b0;
    hold_len = 120;
    for (k = 0; k < 30; k++) begin
      send_request(MW'($urandom_range(0, 5)), IW'($urandom_range(0, 31)), $urandom);
    end
    sender_idle = 1'b1;
  endtask

  task automatic test_random_mix(input int n_items);
    int            k;
    int            r;
    bit            filling;
    logic [MW-1:0] mode;
    logic [IW-1:0] id;
    filling = 1'b1;
    for (k = 0; k < n_items; k++) begin
      if (mirror_count == QDEPTH) filling = 1'b0;
      else if (mirror_count == 0) filling = 1'b1;
      else if ($urandom_range(0, 29) == 0) filling = !filling;
      r = $urandom_range(0, 99);
      if (r < 30) begin
        mode = filling ? deq_pkg::MODE_PUSH_BACK : deq_pkg::MODE_POP_FRONT;
      end else if (r < 55) begin
        mode = filling ? deq_pkg::MODE_PUSH_FRONT : deq_pkg::MODE_POP_BACK;
      end else if (r < 63) begin
        mode = filling ? deq_pkg::MODE_POP_FRONT : deq_pkg::MODE_PUSH_BACK;
      end else if (r < 71) begin
        mode = filling ? deq_pkg::MODE_POP_BACK : deq_pkg::MODE_PUSH_FRONT;
      end else if (r < 94) begin
        mode = deq_pkg::MODE_FIND;
      end else if (r < 97) begin
        mode = deq_pkg::MODE_CLEAR;
      end else begin
        mode = r[0] ? MODE_UNUSED_A : MODE_UNUSED_B;
      end
      if (mode == deq_pkg::MODE_FIND && mirror_count > 0 && $urandom_range(0, 1) == 1) begin
        id = mirror_ids[mirror_head + SLOT_W'($urandom_range(0, mirror_count - 1))];
      end else if ($urandom_range(0, 3) != 0) begin
        id = IW'($urandom_range(0, 31));
      end else begin
        id = IW'($urandom);
      end
      send_request(mode, id, $urandom);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_full_queue();
    test_backpressure();
    test_random_mix(1450);
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    test_random_mix(200);

    in_tvalid <= 1'b0;
    while (deque_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("double_ended_queue_tb: clean");
    end else begin
      $display("double_ended_queue_tb: errors");
    end
    $finish;
  end

endmodule
